FILE: rtl/y2r_pkg.sv
// Shared types and constants for the YUY2 to RGB converter.
`default_nettype none

package y2r_pkg;

  // Output packing codes of the format register
  typedef enum logic [2:0] {
    FMT_Y8    = 3'd0,
    FMT_Y16   = 3'd1,
    FMT_RGB8  = 3'd2,
    FMT_RGBA8 = 3'd3,
    FMT_BGR8  = 3'd4,
    FMT_BGRA8 = 3'd5
  } fmt_e;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [8:0] LUMA_OFFSET  = 9'd16;
  localparam logic [8:0] CHROMA_BIAS  = 9'd128;

  // BT.601 integer coefficients (scaled by 256)
  localparam logic signed [17:0] COEF_Y  = 18'sd298;
  localparam logic signed [17:0] COEF_RV = 18'sd409;
  localparam logic signed [17:0] COEF_GU = 18'sd100;
  localparam logic signed [17:0] COEF_GV = 18'sd208;
  localparam logic signed [17:0] COEF_BU = 18'sd516;

  // One YUY2 macropixel
  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
    logic       in_last;
  } pix_in_t;

  // One packed pixel pair
  typedef struct packed {
    logic [63:0] packed_bytes;
    logic [3:0]  byte_count;
    logic        out_last;
  } pix_out_t;

  // Stage 1: raw products
  typedef struct packed {
    logic [7:0]         y0;
    logic [7:0]         y1;
    logic signed [17:0] luma0;
    logic signed [17:0] luma1;
    logic signed [17:0] r_v;
    logic signed [17:0] g_u;
    logic signed [17:0] g_v;
    logic signed [17:0] b_u;
    logic               last;
  } prod_t;

  // Stage 2: unclamped color sums
  typedef struct packed {
    logic [7:0]         y0;
    logic [7:0]         y1;
    logic signed [10:0] r0;
    logic signed [10:0] g0;
    logic signed [10:0] b0;
    logic signed [10:0] r1;
    logic signed [10:0] g1;
    logic signed [10:0] b1;
    logic               last;
  } sums_t;

endpackage

`default_nettype wire

FILE: rtl/y2r_product.sv
// Stage 1: offset removal and coefficient products.
`default_nettype none

module y2r_product (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire y2r_pkg::pix_in_t data_i,
  output y2r_pkg::prod_t        prod_o
);

  logic signed [17:0] c0, c1, d, e;
  y2r_pkg::prod_t     prod_d, prod_q;

  // Signed offsets, widened for the products
  always_comb begin
    c0 = 18'(signed'({1'b0, data_i.luma_first} - y2r_pkg::LUMA_OFFSET));
    c1 = 18'(signed'({1'b0, data_i.luma_second} - y2r_pkg::LUMA_OFFSET));
    d  = 18'(signed'({1'b0, data_i.chroma_blue} - y2r_pkg::CHROMA_BIAS));
    e  = 18'(signed'({1'b0, data_i.chroma_red} - y2r_pkg::CHROMA_BIAS));
  end

  // Constant products
  always_comb begin
    prod_d.y0    = data_i.luma_first;
    prod_d.y1    = data_i.luma_second;
    prod_d.luma0 = c0 * y2r_pkg::COEF_Y;
    prod_d.luma1 = c1 * y2r_pkg::COEF_Y;
    prod_d.r_v   = e * y2r_pkg::COEF_RV;
    prod_d.g_u   = d * y2r_pkg::COEF_GU;
    prod_d.g_v   = e * y2r_pkg::COEF_GV;
    prod_d.b_u   = d * y2r_pkg::COEF_BU;
    prod_d.last  = data_i.in_last;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

FILE: rtl/y2r_combine.sv
// Stage 2: floor each product by 256 and form the color sums.
`default_nettype none

module y2r_combine (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire y2r_pkg::prod_t prod_i,
  output y2r_pkg::sums_t      sums_o
);

  logic signed [10:0] l0, l1, rv, gu, gv, bu;
  y2r_pkg::sums_t     sums_d, sums_q;

  // Arithmetic shift by 8 floors toward minus infinity
  always_comb begin
    l0 = 11'(signed'(prod_i.luma0[17:8]));
    l1 = 11'(signed'(prod_i.luma1[17:8]));
    rv = 11'(signed'(prod_i.r_v[17:8]));
    gu = 11'(signed'(prod_i.g_u[17:8]));
    gv = 11'(signed'(prod_i.g_v[17:8]));
    bu = 11'(signed'(prod_i.b_u[17:8]));
  end

  always_comb begin
    sums_d.y0   = prod_i.y0;
    sums_d.y1   = prod_i.y1;
    sums_d.r0   = l0 + rv;
    sums_d.g0   = l0 - gu - gv;
    sums_d.b0   = l0 + bu;
    sums_d.r1   = l1 + rv;
    sums_d.g1   = l1 - gu - gv;
    sums_d.b1   = l1 + bu;
    sums_d.last = prod_i.last;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sums_q <= sums_d;
    end
  end

  assign sums_o = sums_q;

endmodule

`default_nettype wire

FILE: rtl/y2r_pack.sv
// Stage 3: clamp to bytes and pack in the selected output format.
`default_nettype none

module y2r_pack (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire y2r_pkg::fmt_e   fmt_i,
  input  wire y2r_pkg::sums_t  sums_i,
  output y2r_pkg::pix_out_t    data_o
);

  function automatic logic [7:0] clamp_byte(input logic signed [10:0] v);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > 11'sd255) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  logic [7:0]         r0, g0, b0, r1, g1, b1;
  y2r_pkg::pix_out_t  data_d, data_q;

  always_comb begin
    r0 = clamp_byte(sums_i.r0);
    g0 = clamp_byte(sums_i.g0);
    b0 = clamp_byte(sums_i.b0);
    r1 = clamp_byte(sums_i.r1);
    g1 = clamp_byte(sums_i.g1);
    b1 = clamp_byte(sums_i.b1);
  end

  // Byte 0 lands in bits 7:0; unused bytes stay zero
  always_comb begin
    data_d.out_last = sums_i.last;
    unique case (fmt_i)
      y2r_pkg::FMT_Y16: begin
        data_d.packed_bytes = {32'd0, sums_i.y1, 8'd0, sums_i.y0, 8'd0};
        data_d.byte_count   = 4'd4;
      end
      y2r_pkg::FMT_RGB8: begin
        data_d.packed_bytes = {16'd0, b1, g1, r1, b0, g0, r0};
        data_d.byte_count   = 4'd6;
      end
      y2r_pkg::FMT_RGBA8: begin
        data_d.packed_bytes = {y2r_pkg::ALPHA_OPAQUE, b1, g1, r1,
                               y2r_pkg::ALPHA_OPAQUE, b0, g0, r0};
        data_d.byte_count   = 4'd8;
      end
      y2r_pkg::FMT_BGR8: begin
        data_d.packed_bytes = {16'd0, r1, g1, b1, r0, g0, b0};
        data_d.byte_count   = 4'd6;
      end
      y2r_pkg::FMT_BGRA8: begin
        data_d.packed_bytes = {y2r_pkg::ALPHA_OPAQUE, r1, g1, b1,
                               y2r_pkg::ALPHA_OPAQUE, r0, g0, b0};
        data_d.byte_count   = 4'd8;
      end
      default: begin
        // Y8, also for undefined codes
        data_d.packed_bytes = {48'd0, sums_i.y1, sums_i.y0};
        data_d.byte_count   = 4'd2;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

FILE: rtl/yuy2_unpack_to_rgb_unit.sv
// Top level: YUY2 macropixel to packed RGB/luma converter, three-stage pipeline.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one YUY2
//   macropixel per transfer. Output channel (out_valid_o / out_stall_i /
//   out_data_o) carries both converted pixels, packed in memory byte order,
//   with the valid byte count and the last flag of the macropixel.
//   An item passes the product, sum and pack registers in turn. Throughput is
//   one macropixel per cycle while out_stall_i is low: products, color sums
//   and clamp/pack each own one register stage.
//   cfg_we_i / cfg_wdata_i write the output format; write it only while the
//   pipeline is empty. Undefined codes pack as Y8.
//   Reset empties the pipeline and selects RGB8.
//   When the receiver stalls, the output holds; bubbles inside the pipeline
//   still fill, and in_stall_o rises only once every stage holds an item.
//
`default_nettype none

module yuy2_unpack_to_rgb_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire y2r_pkg::pix_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output y2r_pkg::pix_out_t      out_data_o
);

  y2r_pkg::fmt_e  fmt_q;
  logic           v1_q, v2_q, v3_q;
  logic           adv1, adv2, adv3;
  y2r_pkg::prod_t prod;
  y2r_pkg::sums_t sums;

  // Format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= y2r_pkg::FMT_RGB8;
    end else if (cfg_we_i) begin
      fmt_q <= y2r_pkg::fmt_e'(cfg_wdata_i);
    end
  end

  // A stage loads when it is empty or its content moves on
  assign adv3 = !v3_q || !out_stall_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= in_valid_i;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  y2r_product u_product (
    .clk_i  (clk_i),
    .en_i   (adv1),
    .data_i (in_data_i),
    .prod_o (prod)
  );

  y2r_combine u_combine (
    .clk_i  (clk_i),
    .en_i   (adv2),
    .prod_i (prod),
    .sums_o (sums)
  );

  y2r_pack u_pack (
    .clk_i  (clk_i),
    .en_i   (adv3),
    .fmt_i  (fmt_q),
    .sums_i (sums),
    .data_o (out_data_o)
  );

  assign in_stall_o  = !adv1;
  assign out_valid_o = v3_q;

endmodule

`default_nettype wire
